// ===== rtl/core/eev_pkg.sv =====
// shared types and constants for the ellipse extent and visibility block
package eev_pkg;

    // test mode codes
    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_PART    = 2'd1;
    localparam logic [1:0] MODE_CENTRE  = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // cordic constants, angles in 2^32 per turn
    localparam int TABLE_LEN = 24;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [29:0] ATAN_TURN [0:TABLE_LEN-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // square root pipeline depth, one result bit per stage
    localparam int SQRT_LAT = 32;
    localparam logic [31:0] WIDTH_MAX = 32'h8000_0000;

    // fields carried alongside the cordic
    typedef struct packed {
        logic [31:0]        mn;
        logic [31:0]        mj;
        logic signed [31:0] xc;
        logic signed [31:0] yc;
        logic signed [31:0] xlo;
        logic signed [31:0] xhi;
        logic signed [31:0] ylo;
        logic signed [31:0] yhi;
        logic [1:0]         mode;
    } side_t;

    // fields carried alongside the square root
    typedef struct packed {
        logic signed [31:0] xc;
        logic signed [31:0] yc;
        logic signed [31:0] xlo;
        logic signed [31:0] xhi;
        logic signed [31:0] ylo;
        logic signed [31:0] yhi;
        logic [1:0]         mode;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } tail_t;

endpackage

// ===== rtl/core/eev_delay.sv =====
// delay line for a valid bit and its payload word
module eev_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg [0:DEPTH-1];
    logic [WIDTH-1:0] data_reg  [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

// ===== rtl/core/eev_cordic.sv =====
// pipelined cordic rotator giving clamped cosine and sine in q2.30
module eev_cordic #(
    parameter int STAGES = 16
) (
    input  logic               clk,
    input  logic [31:0]        angle,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    localparam int ITER = (STAGES < eev_pkg::TABLE_LEN) ? STAGES : eev_pkg::TABLE_LEN;

    logic signed [33:0] x_reg [0:ITER];
    logic signed [33:0] y_reg [0:ITER];
    logic signed [33:0] z_reg [0:ITER];
    logic               flip_reg [0:ITER];

    logic               fold;
    logic [31:0]        angle_next;
    logic signed [33:0] x_fin;
    logic signed [33:0] y_fin;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;

    // second and third quadrants are turned by a half turn and negated after
    assign fold       = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    assign angle_next = fold ? (angle + eev_pkg::HALF_TURN) : angle;

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= eev_pkg::INV_GAIN_Q30;
        y_reg[0]    <= '0;
        z_reg[0]    <= 34'($signed(angle_next));
        flip_reg[0] <= fold;
    end

    for (genvar i = 0; i < ITER; i++)
    begin : g_stage
        localparam logic signed [33:0] ATAN = 34'(eev_pkg::ATAN_TURN[i]);
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][33])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    assign x_fin = flip_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];
    assign y_fin = flip_reg[ITER] ? -y_reg[ITER] : y_reg[ITER];

    always_comb
    begin
        x_next = x_fin;
        y_next = y_fin;
        if (x_fin > eev_pkg::ONE_Q30)  x_next = eev_pkg::ONE_Q30;
        if (x_fin < -eev_pkg::ONE_Q30) x_next = -eev_pkg::ONE_Q30;
        if (y_fin > eev_pkg::ONE_Q30)  y_next = eev_pkg::ONE_Q30;
        if (y_fin < -eev_pkg::ONE_Q30) y_next = -eev_pkg::ONE_Q30;
    end

    // 32 bits so that a clamped value of exactly one still fits
    always_ff @(posedge clk)
    begin
        cos_val <= x_next[31:0];
        sin_val <= y_next[31:0];
    end

endmodule

// ===== rtl/core/eev_sqrt.sv =====
// pipelined integer square root with floor, one root bit per stage
module eev_sqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int N = eev_pkg::SQRT_LAT;

    logic [63:0] v_reg [0:N];
    logic [63:0] r_reg [0:N];

    always_ff @(posedge clk)
    begin
        v_reg[0] <= radicand;
        r_reg[0] <= '0;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_bit
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = r_reg[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (v_reg[k] >= trial)
            begin
                v_reg[k+1] <= v_reg[k] - trial;
                r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
                r_reg[k+1] <= r_reg[k] >> 1;
            end
        end
    end

    assign root = r_reg[N][31:0];

endmodule

// ===== rtl/core/ellipse_extent_and_visibility.sv =====
// top level: rotated ellipse extents, locus point and rectangle visibility
//
// One word is taken whenever start is high; busy is always low, so a new word may
// follow in every cycle. Each word gives exactly one result, shown for one cycle
// with done high, after passing the axis preparation register, which loads at the
// edge that took the word, then the cordic pipeline (input register, iteration
// stages up to the table length, output register), three multiply and sum stages,
// the square root input register and its 32 stages, and the output register. Results
// leave in the order the words came in. The receiver cannot stall the block.
module ellipse_extent_and_visibility #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] minor_axis,
    input  logic signed [31:0] major_axis,
    input  logic signed [15:0] position_angle,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [15:0] locus_angle,
    input  logic signed [31:0] rect_x_a,
    input  logic signed [31:0] rect_x_b,
    input  logic signed [31:0] rect_y_a,
    input  logic signed [31:0] rect_y_b,
    input  logic [1:0]         test_mode,
    output logic               done,
    output logic [31:0]        width_x,
    output logic [31:0]        width_y,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic               visible,
    output logic               mode_error
);

    localparam int ITER = (CORDIC_STAGES < eev_pkg::TABLE_LEN)
                          ? CORDIC_STAGES : eev_pkg::TABLE_LEN;
    localparam int CORDIC_LAT = ITER + 2;

    // never refuses a word
    assign busy = 1'b0;

    // ---- stage 0: absolute axes, ordering, rectangle edge ordering
    logic [31:0]         mn_abs;
    logic [31:0]         mj_abs;
    logic                swap;
    eev_pkg::side_t      s0_side_next;
    logic                s0_valid_reg;
    logic [31:0]         s0_pa_reg;
    logic [31:0]         s0_th_reg;
    eev_pkg::side_t      s0_side_reg;

    assign mn_abs = minor_axis[31] ? (~minor_axis + 32'd1) : minor_axis;
    assign mj_abs = major_axis[31] ? (~major_axis + 32'd1) : major_axis;
    assign swap   = mj_abs < mn_abs;

    always_comb
    begin
        s0_side_next.mn   = swap ? mj_abs : mn_abs;
        s0_side_next.mj   = swap ? mn_abs : mj_abs;
        s0_side_next.xc   = center_x;
        s0_side_next.yc   = center_y;
        s0_side_next.xlo  = (rect_x_a > rect_x_b) ? rect_x_b : rect_x_a;
        s0_side_next.xhi  = (rect_x_a > rect_x_b) ? rect_x_a : rect_x_b;
        s0_side_next.ylo  = (rect_y_a > rect_y_b) ? rect_y_b : rect_y_a;
        s0_side_next.yhi  = (rect_y_a > rect_y_b) ? rect_y_a : rect_y_b;
        s0_side_next.mode = test_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    // swapped axes turn the position angle back by a quarter turn
    always_ff @(posedge clk)
    begin
        s0_pa_reg   <= {position_angle, 16'h0000}
                       - (swap ? eev_pkg::QUARTER_TURN : 32'd0);
        s0_th_reg   <= {locus_angle, 16'h0000};
        s0_side_reg <= s0_side_next;
    end

    // ---- cordic pair, sideband delayed to match
    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] ct;
    logic signed [31:0] st;
    logic               c_valid;
    eev_pkg::side_t     c_side;

    eev_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pa (
        .clk     (clk),
        .angle   (s0_pa_reg),
        .cos_val (cp),
        .sin_val (sp)
    );

    eev_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
        .clk     (clk),
        .angle   (s0_th_reg),
        .cos_val (ct),
        .sin_val (st)
    );

    eev_delay #(.WIDTH($bits(eev_pkg::side_t)), .DEPTH(CORDIC_LAT)) u_delay_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_data   (s0_side_reg),
        .out_valid (c_valid),
        .out_data  (c_side)
    );

    // ---- m1: axis by trig products, rounded
    logic [30:0]        abs_cp;
    logic [30:0]        abs_sp;
    logic [63:0]        pa_full;
    logic [63:0]        pb_full;
    logic [63:0]        pc_full;
    logic [63:0]        pd_full;
    logic signed [63:0] tm_full;
    logic signed [63:0] tj_full;

    logic               m1_valid_reg;
    logic [31:0]        m1_a_reg;
    logic [31:0]        m1_b_reg;
    logic [31:0]        m1_c_reg;
    logic [31:0]        m1_d_reg;
    logic signed [31:0] m1_tm_reg;
    logic signed [31:0] m1_tj_reg;
    logic signed [31:0] m1_cp_reg;
    logic signed [31:0] m1_sp_reg;
    eev_pkg::side_t     m1_side_reg;

    assign abs_cp = cp[31] ? 31'(-cp) : 31'(cp);
    assign abs_sp = sp[31] ? 31'(-sp) : 31'(sp);

    // rounded half up by 30 bits: width terms
    assign pa_full = 64'(c_side.mn) * 64'(abs_cp) + 64'd536870912;
    assign pb_full = 64'(c_side.mj) * 64'(abs_sp) + 64'd536870912;
    assign pc_full = 64'(c_side.mj) * 64'(abs_cp) + 64'd536870912;
    assign pd_full = 64'(c_side.mn) * 64'(abs_sp) + 64'd536870912;
    // rounded half up by 31 bits: halved locus terms
    assign tm_full = $signed({32'd0, c_side.mn}) * 64'(st) + 64'sd1073741824;
    assign tj_full = $signed({32'd0, c_side.mj}) * 64'(ct) + 64'sd1073741824;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_a_reg    <= pa_full[61:30];
        m1_b_reg    <= pb_full[61:30];
        m1_c_reg    <= pc_full[61:30];
        m1_d_reg    <= pd_full[61:30];
        m1_tm_reg   <= tm_full[62:31];
        m1_tj_reg   <= tj_full[62:31];
        m1_cp_reg   <= cp;
        m1_sp_reg   <= sp;
        m1_side_reg <= c_side;
    end

    // ---- m2: squares and rotation products
    logic               m2_valid_reg;
    logic [63:0]        m2_aa_reg;
    logic [63:0]        m2_bb_reg;
    logic [63:0]        m2_cc_reg;
    logic [63:0]        m2_dd_reg;
    logic signed [62:0] m2_px1_reg;
    logic signed [62:0] m2_px2_reg;
    logic signed [62:0] m2_py1_reg;
    logic signed [62:0] m2_py2_reg;
    eev_pkg::side_t     m2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_aa_reg   <= 64'(m1_a_reg) * 64'(m1_a_reg);
        m2_bb_reg   <= 64'(m1_b_reg) * 64'(m1_b_reg);
        m2_cc_reg   <= 64'(m1_c_reg) * 64'(m1_c_reg);
        m2_dd_reg   <= 64'(m1_d_reg) * 64'(m1_d_reg);
        m2_px1_reg  <= 63'(m1_tm_reg) * 63'(m1_cp_reg);
        m2_px2_reg  <= 63'(m1_tj_reg) * 63'(m1_sp_reg);
        m2_py1_reg  <= 63'(m1_tj_reg) * 63'(m1_cp_reg);
        m2_py2_reg  <= 63'(m1_tm_reg) * 63'(m1_sp_reg);
        m2_side_reg <= m1_side_reg;
    end

    // ---- m3: sums of squares, locus point with rounding and saturation
    logic signed [63:0] sx_full;
    logic signed [63:0] sy_full;
    logic signed [34:0] px_wide;
    logic signed [34:0] py_wide;
    eev_pkg::tail_t     m3_tail_next;

    logic               m3_valid_reg;
    logic [63:0]        m3_vx_reg;
    logic [63:0]        m3_vy_reg;
    eev_pkg::tail_t     m3_tail_reg;

    assign sx_full = 64'(m2_px1_reg) + 64'(m2_px2_reg) + 64'sd536870912;
    assign sy_full = 64'(m2_py1_reg) - 64'(m2_py2_reg) + 64'sd536870912;
    assign px_wide = 35'(m2_side_reg.xc) + 35'($signed(sx_full[63:30]));
    assign py_wide = 35'(m2_side_reg.yc) + 35'($signed(sy_full[63:30]));

    always_comb
    begin
        m3_tail_next.xc   = m2_side_reg.xc;
        m3_tail_next.yc   = m2_side_reg.yc;
        m3_tail_next.xlo  = m2_side_reg.xlo;
        m3_tail_next.xhi  = m2_side_reg.xhi;
        m3_tail_next.ylo  = m2_side_reg.ylo;
        m3_tail_next.yhi  = m2_side_reg.yhi;
        m3_tail_next.mode = m2_side_reg.mode;
        // saturate to 32 bits signed
        if (px_wide > 35'sd2147483647)
            m3_tail_next.px = 32'sh7fff_ffff;
        else if (px_wide < -35'sd2147483648)
            m3_tail_next.px = 32'sh8000_0000;
        else
            m3_tail_next.px = px_wide[31:0];
        if (py_wide > 35'sd2147483647)
            m3_tail_next.py = 32'sh7fff_ffff;
        else if (py_wide < -35'sd2147483648)
            m3_tail_next.py = 32'sh8000_0000;
        else
            m3_tail_next.py = py_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m3_vx_reg   <= m2_aa_reg + m2_bb_reg;
        m3_vy_reg   <= m2_cc_reg + m2_dd_reg;
        m3_tail_reg <= m3_tail_next;
    end

    // ---- square roots of both extents
    logic [31:0]    root_x;
    logic [31:0]    root_y;
    logic           q_valid;
    eev_pkg::tail_t q_tail;

    eev_sqrt u_sqrt_x (
        .clk      (clk),
        .radicand (m3_vx_reg),
        .root     (root_x)
    );

    eev_sqrt u_sqrt_y (
        .clk      (clk),
        .radicand (m3_vy_reg),
        .root     (root_y)
    );

    // the root stages hold one extra input register
    eev_delay #(.WIDTH($bits(eev_pkg::tail_t)), .DEPTH(eev_pkg::SQRT_LAT + 1)) u_delay_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m3_valid_reg),
        .in_data   (m3_tail_reg),
        .out_valid (q_valid),
        .out_data  (q_tail)
    );

    // ---- final: clamp widths, ellipse limits and visibility test
    logic [31:0]        wx;
    logic [31:0]        wy;
    logic signed [33:0] exa;
    logic signed [33:0] exb;
    logic signed [33:0] eya;
    logic signed [33:0] eyb;
    logic signed [33:0] xlo;
    logic signed [33:0] xhi;
    logic signed [33:0] ylo;
    logic signed [33:0] yhi;
    logic               vis_next;

    assign wx  = (root_x > eev_pkg::WIDTH_MAX) ? eev_pkg::WIDTH_MAX : root_x;
    assign wy  = (root_y > eev_pkg::WIDTH_MAX) ? eev_pkg::WIDTH_MAX : root_y;
    assign exa = 34'(q_tail.xc) - $signed({2'b00, wx >> 1});
    assign exb = exa + $signed({2'b00, wx});
    assign eya = 34'(q_tail.yc) - $signed({2'b00, wy >> 1});
    assign eyb = eya + $signed({2'b00, wy});
    assign xlo = 34'(q_tail.xlo);
    assign xhi = 34'(q_tail.xhi);
    assign ylo = 34'(q_tail.ylo);
    assign yhi = 34'(q_tail.yhi);

    always_comb
    begin
        case (q_tail.mode)
            eev_pkg::MODE_FULL:
                vis_next = (exa >= xlo) && (exb <= xhi) && (eya >= ylo) && (eyb <= yhi);
            eev_pkg::MODE_PART:
                vis_next = !((exb < xlo) || (exa > xhi) || (eyb < ylo) || (eya > yhi));
            eev_pkg::MODE_CENTRE:
                vis_next = (q_tail.xc >= q_tail.xlo) && (q_tail.xc <= q_tail.xhi)
                        && (q_tail.yc >= q_tail.ylo) && (q_tail.yc <= q_tail.yhi);
            default:
                vis_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        width_x    <= wx;
        width_y    <= wy;
        point_x    <= q_tail.px;
        point_y    <= q_tail.py;
        visible    <= vis_next;
        mode_error <= (q_tail.mode == eev_pkg::MODE_UNKNOWN);
    end

endmodule
